// ----- rtl/wtm_pkg.sv -----
// Shared types, constants and codes for the windowed trimmed-mean statistics unit.
package wtm_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int WIN_FW       = $clog2(WINDOW_DEPTH + 1);
    localparam int WIN_TW       = WIN_FW + 1;
    localparam int BPM_W        = 16;
    localparam int WIN_SUM_W    = WIN_AW + BPM_W + 1;
    localparam int CNT_W        = 32;
    localparam int RSUM_W       = 40;
    localparam int LEVEL_W      = 8;
    localparam int DVD_W        = 48;
    localparam int DVS_W        = 32;
    localparam int QUOT_W       = 16;
    localparam int STEP_W       = $clog2(QUOT_W);
    localparam int NUM_COLORS   = 3;
    localparam int NUM_RATINGS  = 3;

    typedef logic [WIN_AW-1:0]    win_addr_t;
    typedef logic [WIN_FW-1:0]    win_fill_t;
    typedef logic [WIN_TW-1:0]    win_tail_t;
    typedef logic [WIN_SUM_W-1:0] win_sum_t;
    typedef logic [BPM_W-1:0]     bpm_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [RSUM_W-1:0]    rsum_t;
    typedef logic [LEVEL_W-1:0]   level_t;
    typedef logic [DVD_W-1:0]     dvd_t;
    typedef logic [DVS_W-1:0]     dvs_t;
    typedef logic [QUOT_W-1:0]    quot_t;
    typedef logic [STEP_W-1:0]    step_t;

    typedef enum logic [2:0] {
        FUNC_BPM      = 3'd0,
        FUNC_COLOR    = 3'd1,
        FUNC_ANXIETY  = 3'd2,
        FUNC_ENERGY   = 3'd3,
        FUNC_HUMOR    = 3'd4,
        FUNC_SNAPSHOT = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        KIND_ID      = 3'd0,
        KIND_BPM     = 3'd1,
        KIND_ANXIETY = 3'd2,
        KIND_ENERGY  = 3'd3,
        KIND_HUMOR   = 3'd4,
        KIND_GREEN   = 3'd5,
        KIND_YELLOW  = 3'd6,
        KIND_RED     = 3'd7
    } kind_t;

    localparam logic [1:0] REG_BPM_LIMIT  = 2'd0;
    localparam logic [1:0] REG_RATING_MIN = 2'd1;
    localparam logic [1:0] REG_RATING_MAX = 2'd2;

    localparam bpm_t   BPM_LIMIT_RESET  = 16'd64000;
    localparam level_t RATING_MIN_RESET = 8'd1;
    localparam level_t RATING_MAX_RESET = 8'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK,
        ST_EMIT,
        ST_DIV_START,
        ST_DIV_WAIT
    } state_t;

    typedef struct packed {
        logic  update;
        logic  snap_init;
        logic  walk;
        logic  div_start;
        logic  emit;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic div_done;
    } stat_t;

endpackage

// ----- rtl/wtm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/wtm_div.sv -----
// Restoring divider, one quotient bit per cycle, for quotients known to fit 16 bits.
module wtm_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  wtm_pkg::dvd_t  dividend,
    input  wtm_pkg::dvs_t  divisor,
    output logic           done,
    output wtm_pkg::quot_t quotient
);

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    wtm_pkg::step_t        step_reg, step_next;
    wtm_pkg::dvs_t         rem_reg, rem_next;
    wtm_pkg::dvs_t         dvs_reg, dvs_next;
    wtm_pkg::quot_t        low_reg, low_next;
    wtm_pkg::quot_t        quot_reg, quot_next;
    logic [wtm_pkg::DVS_W+1:0] trial;
    logic                  fits;

    always_comb
    begin
        trial = {1'b0, rem_reg, low_reg[wtm_pkg::QUOT_W-1]} - {2'b00, dvs_reg};
        fits  = ~trial[wtm_pkg::DVS_W+1];
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        low_next    = low_reg;
        quot_next   = quot_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            rem_next    = dividend[wtm_pkg::DVD_W-1:wtm_pkg::QUOT_W];
            low_next    = dividend[wtm_pkg::QUOT_W-1:0];
            dvs_next    = divisor;
            quot_next   = '0;
        end
        else if (active_reg)
        begin
            if (fits)
            begin
                rem_next = trial[wtm_pkg::DVS_W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[wtm_pkg::DVS_W-2:0], low_reg[wtm_pkg::QUOT_W-1]};
            end
            low_next  = {low_reg[wtm_pkg::QUOT_W-2:0], 1'b0};
            quot_next = {quot_reg[wtm_pkg::QUOT_W-2:0], fits};
            step_next = step_reg + wtm_pkg::step_t'(1);
            if (step_reg == wtm_pkg::step_t'(wtm_pkg::QUOT_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- rtl/wtm_datapath.sv -----
// Datapath: event counters, heart-rate window, snapshot walk, divider and result registers.
module wtm_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  wtm_pkg::cmd_t cmd,
    output wtm_pkg::stat_t stat,
    input  logic [2:0]    func,
    input  logic [15:0]   bpm_value,
    input  logic [7:0]    color_index,
    input  logic [7:0]    rating_level,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output logic          result_strobe,
    output logic [2:0]    item_kind,
    output logic [31:0]   tally,
    output logic [15:0]   mean_value,
    output logic          mean_valid,
    output logic          last_of_run
);

    function automatic wtm_pkg::win_addr_t next_addr(input wtm_pkg::win_addr_t a);
        if (a == wtm_pkg::win_addr_t'(wtm_pkg::WINDOW_DEPTH - 1))
        begin
            return '0;
        end
        return a + wtm_pkg::win_addr_t'(1);
    endfunction

    // event state
    wtm_pkg::win_addr_t head_reg, head_next;
    wtm_pkg::win_fill_t fill_reg, fill_next;
    wtm_pkg::cnt_t      color_cnt_reg [wtm_pkg::NUM_COLORS];
    wtm_pkg::cnt_t      color_cnt_next [wtm_pkg::NUM_COLORS];
    wtm_pkg::cnt_t      rating_cnt_reg [wtm_pkg::NUM_RATINGS];
    wtm_pkg::cnt_t      rating_cnt_next [wtm_pkg::NUM_RATINGS];
    wtm_pkg::rsum_t     rating_sum_reg [wtm_pkg::NUM_RATINGS];
    wtm_pkg::rsum_t     rating_sum_next [wtm_pkg::NUM_RATINGS];
    wtm_pkg::cnt_t      event_id_reg, event_id_next;
    wtm_pkg::bpm_t      bpm_limit_reg, bpm_limit_next;
    wtm_pkg::level_t    rating_min_reg, rating_min_next;
    wtm_pkg::level_t    rating_max_reg, rating_max_next;

    // snapshot walk
    wtm_pkg::win_addr_t rd_ptr_reg, rd_ptr_next;
    wtm_pkg::win_fill_t walk_cnt_reg, walk_cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    wtm_pkg::win_sum_t  acc_sum_reg, acc_sum_next;
    wtm_pkg::bpm_t      acc_lo_reg, acc_lo_next;
    wtm_pkg::bpm_t      acc_hi_reg, acc_hi_next;

    // results
    logic               strobe_reg, strobe_next;
    wtm_pkg::kind_t     kind_reg, kind_next;
    wtm_pkg::cnt_t      tally_reg, tally_next;
    wtm_pkg::quot_t     mean_reg, mean_next;
    logic               valid_reg, valid_next;

    // window RAM and divider
    logic               ram_we, ram_re;
    wtm_pkg::win_addr_t ram_waddr;
    wtm_pkg::bpm_t      ram_rdata;
    wtm_pkg::win_tail_t tail_sum;
    wtm_pkg::win_addr_t tail_addr;
    wtm_pkg::dvd_t      div_dvd;
    wtm_pkg::dvs_t      div_dvs;
    wtm_pkg::quot_t     div_quot;
    logic               div_done;
    wtm_pkg::win_sum_t  bpm_trim;
    logic               bpm_small;
    wtm_pkg::level_t    level_clamped;
    logic [2:0]         rating_off;
    logic [1:0]         ridx;
    logic [1:0]         cidx;

    wtm_ram #(
        .WIDTH (wtm_pkg::BPM_W),
        .DEPTH (wtm_pkg::WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (bpm_value),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    wtm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        tail_sum = wtm_pkg::win_tail_t'(head_reg) + wtm_pkg::win_tail_t'(fill_reg);
        if (tail_sum >= wtm_pkg::win_tail_t'(wtm_pkg::WINDOW_DEPTH))
        begin
            tail_addr = wtm_pkg::win_addr_t'(tail_sum - wtm_pkg::win_tail_t'(wtm_pkg::WINDOW_DEPTH));
        end
        else
        begin
            tail_addr = wtm_pkg::win_addr_t'(tail_sum);
        end

        if (rating_level < rating_min_reg)
        begin
            level_clamped = rating_min_reg;
        end
        else if (rating_level > rating_max_reg)
        begin
            level_clamped = rating_max_reg;
        end
        else
        begin
            level_clamped = rating_level;
        end
        rating_off = func - 3'(wtm_pkg::FUNC_ANXIETY);
        ridx       = rating_off[1:0];
        cidx       = color_index[1:0];
    end

    // event updates and register writes
    always_comb
    begin
        head_next       = head_reg;
        fill_next       = fill_reg;
        color_cnt_next  = color_cnt_reg;
        rating_cnt_next = rating_cnt_reg;
        rating_sum_next = rating_sum_reg;
        event_id_next   = event_id_reg;
        bpm_limit_next  = bpm_limit_reg;
        rating_min_next = rating_min_reg;
        rating_max_next = rating_max_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_addr;
        if (cmd.update)
        begin
            case (func)
                wtm_pkg::FUNC_BPM:
                begin
                    if (bpm_value != '0 && bpm_value < bpm_limit_reg)
                    begin
                        ram_we = 1'b1;
                        if (fill_reg < wtm_pkg::win_fill_t'(wtm_pkg::WINDOW_DEPTH))
                        begin
                            fill_next = fill_reg + wtm_pkg::win_fill_t'(1);
                        end
                        else
                        begin
                            ram_waddr = head_reg;
                            head_next = next_addr(head_reg);
                        end
                        event_id_next = event_id_reg + 32'd1;
                    end
                end
                wtm_pkg::FUNC_COLOR:
                begin
                    if (color_index < 8'(wtm_pkg::NUM_COLORS))
                    begin
                        if (color_cnt_reg[cidx] != '1)
                        begin
                            color_cnt_next[cidx] = color_cnt_reg[cidx] + 32'd1;
                        end
                        event_id_next = event_id_reg + 32'd1;
                    end
                end
                wtm_pkg::FUNC_ANXIETY, wtm_pkg::FUNC_ENERGY, wtm_pkg::FUNC_HUMOR:
                begin
                    if (rating_cnt_reg[ridx] != '1)
                    begin
                        rating_cnt_next[ridx] = rating_cnt_reg[ridx] + 32'd1;
                        rating_sum_next[ridx] = rating_sum_reg[ridx]
                                                + wtm_pkg::rsum_t'(level_clamped);
                    end
                    event_id_next = event_id_reg + 32'd1;
                end
                default:
                begin
                end
            endcase
        end
        if (cfg_we)
        begin
            case (cfg_index)
                wtm_pkg::REG_BPM_LIMIT:  bpm_limit_next  = cfg_data;
                wtm_pkg::REG_RATING_MIN: rating_min_next = cfg_data[7:0];
                wtm_pkg::REG_RATING_MAX: rating_max_next = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // window walk: one read issued per cycle, its data folded in on the cycle after
    always_comb
    begin
        rd_ptr_next   = rd_ptr_reg;
        walk_cnt_next = walk_cnt_reg;
        rd_pend_next  = rd_pend_reg;
        acc_sum_next  = acc_sum_reg;
        acc_lo_next   = acc_lo_reg;
        acc_hi_next   = acc_hi_reg;
        ram_re        = 1'b0;
        if (cmd.snap_init)
        begin
            rd_ptr_next   = head_reg;
            walk_cnt_next = '0;
            rd_pend_next  = 1'b0;
            acc_sum_next  = '0;
            acc_lo_next   = '1;
            acc_hi_next   = '0;
        end
        else if (cmd.walk)
        begin
            if (walk_cnt_reg != fill_reg)
            begin
                ram_re        = 1'b1;
                rd_ptr_next   = next_addr(rd_ptr_reg);
                walk_cnt_next = walk_cnt_reg + wtm_pkg::win_fill_t'(1);
                rd_pend_next  = 1'b1;
            end
            else
            begin
                rd_pend_next = 1'b0;
            end
            if (rd_pend_reg)
            begin
                acc_sum_next = acc_sum_reg + wtm_pkg::win_sum_t'(ram_rdata);
                if (ram_rdata < acc_lo_reg)
                begin
                    acc_lo_next = ram_rdata;
                end
                if (ram_rdata > acc_hi_reg)
                begin
                    acc_hi_next = ram_rdata;
                end
            end
        end
    end

    assign stat.walk_done = (walk_cnt_reg == fill_reg) && !rd_pend_reg;
    assign stat.div_done  = div_done;

    // divider operands
    always_comb
    begin
        bpm_trim  = acc_sum_reg - wtm_pkg::win_sum_t'(acc_lo_reg)
                    - wtm_pkg::win_sum_t'(acc_hi_reg);
        bpm_small = fill_reg < wtm_pkg::win_fill_t'(3);
        case (cmd.kind)
            wtm_pkg::KIND_BPM:
            begin
                if (bpm_small)
                begin
                    div_dvd = wtm_pkg::dvd_t'(acc_sum_reg);
                    div_dvs = wtm_pkg::dvs_t'(fill_reg);
                end
                else
                begin
                    div_dvd = wtm_pkg::dvd_t'(bpm_trim);
                    div_dvs = wtm_pkg::dvs_t'(fill_reg - wtm_pkg::win_fill_t'(2));
                end
            end
            wtm_pkg::KIND_ANXIETY:
            begin
                div_dvd = {rating_sum_reg[0], 8'h00};
                div_dvs = rating_cnt_reg[0];
            end
            wtm_pkg::KIND_ENERGY:
            begin
                div_dvd = {rating_sum_reg[1], 8'h00};
                div_dvs = rating_cnt_reg[1];
            end
            wtm_pkg::KIND_HUMOR:
            begin
                div_dvd = {rating_sum_reg[2], 8'h00};
                div_dvs = rating_cnt_reg[2];
            end
            default:
            begin
                div_dvd = '0;
                div_dvs = '0;
            end
        endcase
    end

    // result registers
    always_comb
    begin
        strobe_next = cmd.emit;
        kind_next   = kind_reg;
        tally_next  = tally_reg;
        mean_next   = mean_reg;
        valid_next  = valid_reg;
        if (cmd.emit)
        begin
            kind_next = cmd.kind;
            case (cmd.kind)
                wtm_pkg::KIND_ID:
                begin
                    tally_next = event_id_reg;
                    valid_next = 1'b0;
                end
                wtm_pkg::KIND_BPM:
                begin
                    tally_next = wtm_pkg::cnt_t'(fill_reg);
                    valid_next = fill_reg != '0;
                end
                wtm_pkg::KIND_ANXIETY:
                begin
                    tally_next = rating_cnt_reg[0];
                    valid_next = rating_cnt_reg[0] != '0;
                end
                wtm_pkg::KIND_ENERGY:
                begin
                    tally_next = rating_cnt_reg[1];
                    valid_next = rating_cnt_reg[1] != '0;
                end
                wtm_pkg::KIND_HUMOR:
                begin
                    tally_next = rating_cnt_reg[2];
                    valid_next = rating_cnt_reg[2] != '0;
                end
                wtm_pkg::KIND_GREEN:
                begin
                    tally_next = color_cnt_reg[0];
                    valid_next = 1'b0;
                end
                wtm_pkg::KIND_YELLOW:
                begin
                    tally_next = color_cnt_reg[1];
                    valid_next = 1'b0;
                end
                default:
                begin
                    tally_next = color_cnt_reg[2];
                    valid_next = 1'b0;
                end
            endcase
            mean_next = valid_next ? div_quot : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            fill_reg       <= '0;
            event_id_reg   <= '0;
            bpm_limit_reg  <= wtm_pkg::BPM_LIMIT_RESET;
            rating_min_reg <= wtm_pkg::RATING_MIN_RESET;
            rating_max_reg <= wtm_pkg::RATING_MAX_RESET;
            for (int i = 0; i < wtm_pkg::NUM_COLORS; i++)
            begin
                color_cnt_reg[i] <= '0;
            end
            for (int i = 0; i < wtm_pkg::NUM_RATINGS; i++)
            begin
                rating_cnt_reg[i] <= '0;
                rating_sum_reg[i] <= '0;
            end
            walk_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            event_id_reg   <= event_id_next;
            bpm_limit_reg  <= bpm_limit_next;
            rating_min_reg <= rating_min_next;
            rating_max_reg <= rating_max_next;
            color_cnt_reg  <= color_cnt_next;
            rating_cnt_reg <= rating_cnt_next;
            rating_sum_reg <= rating_sum_next;
            walk_cnt_reg   <= walk_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg  <= rd_ptr_next;
        acc_sum_reg <= acc_sum_next;
        acc_lo_reg  <= acc_lo_next;
        acc_hi_reg  <= acc_hi_next;
        kind_reg    <= kind_next;
        tally_reg   <= tally_next;
        mean_reg    <= mean_next;
        valid_reg   <= valid_next;
    end

    assign result_strobe = strobe_reg;
    assign item_kind     = kind_reg;
    assign tally         = tally_reg;
    assign mean_value    = mean_reg;
    assign mean_valid    = valid_reg;
    assign last_of_run   = kind_reg == wtm_pkg::KIND_RED;

endmodule

// ----- rtl/wtm_ctrl.sv -----
// Controller state machine: event update, window walk, division and result sequencing.
module wtm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2:0]     func,
    input  wtm_pkg::stat_t stat,
    output wtm_pkg::cmd_t  cmd,
    output logic           busy
);

    wtm_pkg::state_t state_reg, state_next;
    wtm_pkg::kind_t  kind_reg, kind_next;
    wtm_pkg::kind_t  kind_inc;

    assign kind_inc = wtm_pkg::kind_t'(kind_reg + 3'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            wtm_pkg::ST_IDLE:
            begin
                if (start && func == wtm_pkg::FUNC_SNAPSHOT)
                begin
                    state_next = wtm_pkg::ST_INIT;
                end
            end
            wtm_pkg::ST_INIT:
            begin
                state_next = wtm_pkg::ST_WALK;
            end
            wtm_pkg::ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    kind_next  = wtm_pkg::KIND_ID;
                    state_next = wtm_pkg::ST_EMIT;
                end
            end
            wtm_pkg::ST_EMIT:
            begin
                if (kind_reg == wtm_pkg::KIND_RED)
                begin
                    state_next = wtm_pkg::ST_IDLE;
                end
                else
                begin
                    kind_next = kind_inc;
                    if (kind_inc == wtm_pkg::KIND_BPM || kind_inc == wtm_pkg::KIND_ANXIETY
                        || kind_inc == wtm_pkg::KIND_ENERGY || kind_inc == wtm_pkg::KIND_HUMOR)
                    begin
                        state_next = wtm_pkg::ST_DIV_START;
                    end
                end
            end
            wtm_pkg::ST_DIV_START:
            begin
                state_next = wtm_pkg::ST_DIV_WAIT;
            end
            wtm_pkg::ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = wtm_pkg::ST_EMIT;
                end
            end
            default:
            begin
                state_next = wtm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.update    = 1'b0;
        cmd.snap_init = 1'b0;
        cmd.walk      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.emit      = 1'b0;
        cmd.kind      = kind_reg;
        busy          = 1'b1;
        case (state_reg)
            wtm_pkg::ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.update = start;
            end
            wtm_pkg::ST_INIT:      cmd.snap_init = 1'b1;
            wtm_pkg::ST_WALK:      cmd.walk      = 1'b1;
            wtm_pkg::ST_EMIT:      cmd.emit      = 1'b1;
            wtm_pkg::ST_DIV_START: cmd.div_start = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtm_pkg::ST_IDLE;
            kind_reg  <= wtm_pkg::KIND_ID;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// ----- rtl/windowed_trimmed_mean_stats_unit.sv -----
// Top level of the windowed trimmed-mean statistics unit.
//
// Command channel: an item (func and its fields) is taken when start is high
// and busy is low. Funcs 0 to 4 update the event state in that same cycle and
// leave busy low, so such items may follow one another every cycle. Funcs 6
// and 7 are dropped.
// A snapshot (func 5) raises busy and produces eight results, one per strobe
// cycle on result_strobe, in kind order 0 to 7; last_of_run marks kind 7.
// The receiver cannot stall; each result is shown for one cycle only.
// A snapshot keeps busy high while it makes one window RAM read per cycle
// to sum the window and find its minimum and maximum, then four 16-step
// divisions on one shared divider (trimmed bpm mean, three rating means),
// each followed by its result; the last result lands as busy falls.
// Configuration: cfg_ready is always high; a write with cfg_valid sets the
// register at cfg_index. Writes must be made by the user only while the
// block is idle; the block itself does not enforce this.
// Reset (rst_n low) empties the window, clears all counters and the sample
// id, and restores the limit and clamp registers to their reset values.
module windowed_trimmed_mean_stats_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [15:0] bpm_value,
    input  logic [7:0]  color_index,
    input  logic [7:0]  rating_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_strobe,
    output logic [2:0]  item_kind,
    output logic [31:0] tally,
    output logic [15:0] mean_value,
    output logic        mean_valid,
    output logic        last_of_run
);

    wtm_pkg::cmd_t  cmd;
    wtm_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    wtm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    wtm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .bpm_value     (bpm_value),
        .color_index   (color_index),
        .rating_level  (rating_level),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .item_kind     (item_kind),
        .tally         (tally),
        .mean_value    (mean_value),
        .mean_valid    (mean_valid),
        .last_of_run   (last_of_run)
    );

    a_update_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func != wtm_pkg::FUNC_SNAPSHOT |=> !busy)
        else $error("non-snapshot item raised busy");

    a_snapshot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == wtm_pkg::FUNC_SNAPSHOT |=> busy)
        else $error("snapshot item did not raise busy");

    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_of_run |-> busy)
        else $error("result outside a snapshot run");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last_of_run |=> !result_strobe)
        else $error("result after the last of a run");

    a_mean_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && mean_valid |-> (item_kind == wtm_pkg::KIND_BPM
            || item_kind == wtm_pkg::KIND_ANXIETY || item_kind == wtm_pkg::KIND_ENERGY
            || item_kind == wtm_pkg::KIND_HUMOR))
        else $error("valid mean on a kind without a mean");

endmodule

// ----- tb/sv/tb_windowed_trimmed_mean_stats_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: directed and random health events against a cycle-free predictor.
module tb_windowed_trimmed_mean_stats_unit;
    import wtm_pkg::*;

    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
    localparam int NUM_PHASES    = 5;
    localparam int PHASE_ITEMS   = 94;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        kind_t kind;
        cnt_t  tally;
        bpm_t  mean;
        logic  valid;
        logic  last;
    } stat_item_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic [2:0]  func          = '0;
    logic [15:0] bpm_value     = '0;
    logic [7:0]  color_index   = '0;
    logic [7:0]  rating_level  = '0;
    logic        cfg_valid     = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;
    logic        busy;
    logic        cfg_ready;
    logic        result_strobe;
    logic [2:0]  item_kind;
    logic [31:0] tally;
    logic [15:0] mean_value;
    logic        mean_valid;
    logic        last_of_run;

    bpm_t        win_mem [WINDOW_DEPTH];
    int unsigned win_head;
    int unsigned win_fill;
    cnt_t        color_cnt [NUM_COLORS];
    cnt_t        rating_cnt [NUM_RATINGS];
    rsum_t       rating_sum [NUM_RATINGS];
    cnt_t        event_tag;
    bpm_t        limit_reg;
    level_t      rmin_reg;
    level_t      rmax_reg;

    stat_item_t  expected_stats [$];
    int          mismatch_count = 0;
    int          idle_pct       = 11;
    bit          cmd_held       = 1'b0;

    windowed_trimmed_mean_stats_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .bpm_value     (bpm_value),
        .color_index   (color_index),
        .rating_level  (rating_level),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .item_kind     (item_kind),
        .tally         (tally),
        .mean_value    (mean_value),
        .mean_valid    (mean_valid),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_stat(kind_t k, cnt_t t, bpm_t m, logic v);
        stat_item_t s;
        s.kind  = k;
        s.tally = t;
        s.mean  = m;
        s.valid = v;
        s.last  = (k == KIND_RED);
        expected_stats.push_back(s);
    endfunction

    function automatic void push_snapshot();
        logic [31:0] sum;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] x;
        logic [47:0] scaled;
        bpm_t        m;
        sum = '0;
        lo  = 32'hFFFF;
        hi  = '0;
        push_stat(KIND_ID, event_tag, '0, 1'b0);
        for (int i = 0; i < win_fill; i++)
        begin
            x = win_mem[(win_head + i) % WINDOW_DEPTH];
            sum += x;
            if (x < lo) lo = x;
            if (x > hi) hi = x;
        end
        if (win_fill == 0)
            m = '0;
        else if (win_fill <= 2)
            m = bpm_t'(sum / win_fill);
        else
            m = bpm_t'((sum - lo - hi) / (win_fill - 2));
        push_stat(KIND_BPM, cnt_t'(win_fill), m, win_fill != 0);
        for (int r = 0; r < NUM_RATINGS; r++)
        begin
            scaled = {rating_sum[r], 8'd0};
            m = (rating_cnt[r] != 0) ? bpm_t'(scaled / rating_cnt[r]) : '0;
            push_stat(kind_t'(KIND_ANXIETY + r), rating_cnt[r], m, rating_cnt[r] != 0);
        end
        for (int r = 0; r < NUM_COLORS; r++)
            push_stat(kind_t'(KIND_GREEN + r), color_cnt[r], '0, 1'b0);
    endfunction

    // Advance the predictor by one accepted item.
    function automatic void apply_event(logic [2:0] f, bpm_t b, logic [7:0] c, level_t l);
        level_t lv;
        int     idx;
        case (f)
            FUNC_BPM:
            begin
                if (b == 0 || b >= limit_reg)
                    return;
                if (win_fill < WINDOW_DEPTH)
                begin
                    win_mem[(win_head + win_fill) % WINDOW_DEPTH] = b;
                    win_fill++;
                end
                else
                begin
                    win_mem[win_head] = b;
                    win_head = (win_head + 1) % WINDOW_DEPTH;
                end
                event_tag++;
            end
            FUNC_COLOR:
            begin
                if (c >= NUM_COLORS)
                    return;
                if (color_cnt[c] != '1)
                    color_cnt[c]++;
                event_tag++;
            end
            FUNC_ANXIETY, FUNC_ENERGY, FUNC_HUMOR:
            begin
                idx = int'(f) - int'(FUNC_ANXIETY);
                lv  = l;
                if (lv < rmin_reg)
                    lv = rmin_reg;
                else if (lv > rmax_reg)
                    lv = rmax_reg;
                if (rating_cnt[idx] != '1)
                begin
                    rating_cnt[idx]++;
                    rating_sum[idx] += lv;
                end
                event_tag++;
            end
            FUNC_SNAPSHOT:
            begin
                push_snapshot();
            end
            default:
                return;
        endcase
    endfunction

    always @(posedge clk)
    begin : check_results
        stat_item_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_stats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result kind %0d tally %0d mean %0d",
                             $time, item_kind, tally, mean_value);
            end
            else
            begin
                want = expected_stats.pop_front();
                if (item_kind !== want.kind || tally !== want.tally ||
                    mean_value !== want.mean || mean_valid !== want.valid ||
                    last_of_run !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp kind %0d tally %0d mean %0d valid %0b last %0b%s",
                                 $time, want.kind, want.tally, want.mean, want.valid,
                                 want.last, "");
                    if (mismatch_count <= MAX_REPORTS)
                        $display("        got kind %0d tally %0d mean %0d valid %0b last %0b",
                                 item_kind, tally, mean_value, mean_valid, last_of_run);
                end
            end
        end
    end

    task automatic release_cmd();
        if (cmd_held)
        begin
            start    <= 1'b0;
            cmd_held  = 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_item(logic [2:0] f, bpm_t b, logic [7:0] c, level_t l);
        if ($urandom_range(99) < idle_pct)
        begin
            release_cmd();
        end
        start        <= 1'b1;
        func         <= f;
        bpm_value    <= b;
        color_index  <= c;
        rating_level <= l;
        cmd_held      = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        apply_event(f, b, c, l);
    endtask

    task automatic wait_results_done();
        int guard;
        guard = 0;
        release_cmd();
        while ((expected_stats.size() != 0 || busy) && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        release_cmd();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_BPM_LIMIT:  limit_reg = data;
            REG_RATING_MIN: rmin_reg  = data[7:0];
            REG_RATING_MAX: rmax_reg  = data[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(bpm_t lim, level_t lo, level_t hi);
        wait_results_done();
        write_reg(REG_BPM_LIMIT, lim);
        write_reg(REG_RATING_MIN, {8'($urandom), lo});
        write_reg(REG_RATING_MAX, {8'($urandom), hi});
    endtask

    task automatic test_empty_snapshot();
        send_item(FUNC_SNAPSHOT, bpm_t'($urandom), 8'($urandom), level_t'($urandom));
    endtask

    task automatic test_bpm_window();
        send_item(FUNC_BPM, 16'd0, 8'd0, 8'd0);
        send_item(FUNC_BPM, BPM_LIMIT_RESET, 8'd0, 8'd0);
        send_item(FUNC_BPM, 16'hFFFF, 8'd0, 8'd0);
        send_item(FUNC_BPM, 16'd1, 8'd0, 8'd0);
        send_item(FUNC_BPM, BPM_LIMIT_RESET - 16'd1, 8'd0, 8'd0);
        send_item(FUNC_SNAPSHOT, 16'd0, 8'd0, 8'd0);
        send_item(FUNC_BPM, 16'h4B80, 8'd0, 8'd0);
        send_item(FUNC_SNAPSHOT, 16'd0, 8'd0, 8'd0);
    endtask

    task automatic test_color_events();
        send_item(FUNC_COLOR, 16'd0, 8'd0, 8'd0);
        send_item(FUNC_COLOR, 16'd0, 8'd1, 8'd0);
        send_item(FUNC_COLOR, 16'd0, 8'd2, 8'd0);
        send_item(FUNC_COLOR, 16'd0, 8'd3, 8'd0);
        send_item(FUNC_COLOR, 16'd0, 8'hFF, 8'd0);
        send_item(FUNC_SNAPSHOT, 16'd0, 8'd0, 8'd0);
    endtask

    task automatic test_ratings();
        send_item(FUNC_ANXIETY, 16'd0, 8'd0, 8'd0);
        send_item(FUNC_ENERGY, 16'd0, 8'd0, 8'hFF);
        send_item(FUNC_HUMOR, 16'd0, 8'd0, 8'd3);
        send_item(FUNC_SPARE_6, 16'd100, 8'd1, 8'd2);
        send_item(FUNC_SPARE_7, 16'd100, 8'd1, 8'd2);
        send_item(FUNC_SNAPSHOT, 16'd0, 8'd0, 8'd0);
    endtask

    task automatic test_crossed_clamps();
        set_config(16'hFFFF, 8'd200, 8'd10);
        send_item(FUNC_ANXIETY, 16'd0, 8'd0, 8'd100);
        send_item(FUNC_ENERGY, 16'd0, 8'd0, 8'd250);
        send_item(FUNC_BPM, 16'hFFFE, 8'd0, 8'd0);
        send_item(FUNC_SNAPSHOT, 16'd0, 8'd0, 8'd0);
    endtask

    task automatic test_random();
        int          done;
        int          pick;
        logic [2:0]  f;
        bpm_t        b;
        logic [7:0]  c;
        level_t      l;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: set_config(BPM_LIMIT_RESET, RATING_MIN_RESET, RATING_MAX_RESET);
                1: set_config(16'hFFFF, 8'd0, 8'hFF);
                2: set_config(bpm_t'($urandom_range(65535, 1)), level_t'($urandom),
                              level_t'($urandom));
                3: set_config(16'd1, 8'hFF, 8'd0);
                default: set_config(bpm_t'($urandom_range(65535, 16'h4000)),
                                    level_t'($urandom_range(3)),
                                    level_t'($urandom_range(255, 2)));
            endcase
            idle_pct = (p == 1) ? 0 : 11;
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                b = bpm_t'($urandom);
                c = 8'($urandom);
                l = level_t'($urandom);
                if (pick < 35)
                begin
                    f = FUNC_BPM;
                    case ($urandom_range(3))
                        0: b = bpm_t'(int'(limit_reg) - 2 + $urandom_range(3));
                        1: b = bpm_t'({8'($urandom_range(200, 40)), 8'($urandom)});
                        default: ;
                    endcase
                end
                else if (pick < 50)
                begin
                    f = FUNC_COLOR;
                    if ($urandom_range(4) != 0)
                        c = 8'($urandom_range(2));
                end
                else if (pick < 60)
                    f = FUNC_ANXIETY;
                else if (pick < 70)
                    f = FUNC_ENERGY;
                else if (pick < 80)
                    f = FUNC_HUMOR;
                else if (pick < 96)
                    f = FUNC_SNAPSHOT;
                else if (pick < 98)
                    f = FUNC_SPARE_6;
                else
                    f = FUNC_SPARE_7;
                if ($urandom_range(9) < 3)
                    l = level_t'($urandom_range(6));
                send_item(f, b, c, l);
                done++;
                if (f == FUNC_SNAPSHOT && $urandom_range(9) == 0)
                    wait_results_done();
            end
        end
    endtask

    initial
    begin
        win_head  = 0;
        win_fill  = 0;
        event_tag = '0;
        limit_reg = BPM_LIMIT_RESET;
        rmin_reg  = RATING_MIN_RESET;
        rmax_reg  = RATING_MAX_RESET;
        for (int i = 0; i < NUM_COLORS; i++)
            color_cnt[i] = '0;
        for (int i = 0; i < NUM_RATINGS; i++)
        begin
            rating_cnt[i] = '0;
            rating_sum[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_snapshot();
        test_bpm_window();
        test_color_events();
        test_ratings();
        test_crossed_clamps();
        test_random();

        wait_results_done();
        if (mismatch_count == 0 && expected_stats.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
